FILE: rtl/gmv_pkg.sv
// gmv_pkg: constants, widths and shared types of the GF(2) matrix-vector unit.
// No dependencies; imported by every other file of the block.
package gmv_pkg;

    localparam int MAX_ROW_WORDS = 128;
    localparam int MAX_ROWS      = 2048;
    localparam int WORD_W        = 32;

    localparam int ADDR_W        = $clog2(MAX_ROW_WORDS);
    localparam int ROW_POS_W     = $clog2(MAX_ROWS);
    localparam int ROW_WORDS_W   = 8;
    localparam int ROW_COUNT_W   = 12;
    localparam int CFG_DATA_W    = 12;
    localparam int CFG_INDEX_W   = 1;
    localparam int BYTE_IDX_W    = 8;
    localparam int MASK_W        = 8;
    localparam int BIT_POS_W     = 3;

    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_MATRIX = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_ROW_WORDS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT = 1'b1;

    typedef struct packed {
        logic              is_matrix;
        logic [ADDR_W-1:0] index;
        logic [WORD_W-1:0] data;
    } op_t;

    typedef struct packed {
        logic [ROW_WORDS_W-1:0] eff_words;
        logic [ROW_COUNT_W-1:0] eff_rows;
    } cfg_t;

endpackage

FILE: rtl/gmv_if.sv
// Handshake interfaces for the input words and the result masks.
// Depends on gmv_pkg for field widths.
interface gmv_in_if
    import gmv_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              func;
    logic [ADDR_W-1:0] vector_index;
    logic [WORD_W-1:0] data_word;

    modport source (output valid, output func, output vector_index, output data_word,
                    input ready);
    modport sink   (input valid, input func, input vector_index, input data_word,
                    output ready);
endinterface

interface gmv_out_if
    import gmv_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [BYTE_IDX_W-1:0] byte_index;
    logic [MASK_W-1:0]     xor_mask;
    logic                  last_byte;

    modport source (output valid, output byte_index, output xor_mask, output last_byte,
                    input ready);
    modport sink   (input valid, input byte_index, input xor_mask, input last_byte,
                    output ready);
endinterface

FILE: rtl/gf2_matrix_vector_madd_unit.sv
// GF(2) matrix-vector multiply-accumulate: one word per cycle sustained while the result output is not stalled.
// The word that ends a byte passes the input queue and the b2 stage before its result is registered at the output.
// Throughput is set by the single vector store port and the one-word accumulator.
// Reset: row_words and row_count return to 1, queue, counters and accumulator clear;
// the vector store is not cleared and holds garbage until loaded.
// Depends on gmv_pkg, gmv_if, gmv_front and gmv_back.
module gf2_matrix_vector_madd_unit
    import gmv_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    gmv_in_if.sink                 item,
    gmv_out_if.source              result,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data
);

    logic [ROW_WORDS_W-1:0] row_words_reg;
    logic [ROW_COUNT_W-1:0] row_count_reg;
    cfg_t                   cfg;
    logic                   q_valid;
    op_t                    q_op;
    logic                   q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_words_reg <= ROW_WORDS_W'(1);
            row_count_reg <= ROW_COUNT_W'(1);
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_ROW_WORDS: row_words_reg <= wr_data[ROW_WORDS_W-1:0];
                REG_ROW_COUNT: row_count_reg <= wr_data[ROW_COUNT_W-1:0];
                default:       ;
            endcase
        end
    end

    // clamp to 1..max
    always_comb
    begin
        if (row_words_reg == '0)
            cfg.eff_words = ROW_WORDS_W'(1);
        else if (row_words_reg > ROW_WORDS_W'(MAX_ROW_WORDS))
            cfg.eff_words = ROW_WORDS_W'(MAX_ROW_WORDS);
        else
            cfg.eff_words = row_words_reg;

        if (row_count_reg == '0)
            cfg.eff_rows = ROW_COUNT_W'(1);
        else if (row_count_reg > ROW_COUNT_W'(MAX_ROWS))
            cfg.eff_rows = ROW_COUNT_W'(MAX_ROWS);
        else
            cfg.eff_rows = row_count_reg;
    end

    gmv_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .q_valid (q_valid),
        .q_op    (q_op),
        .q_pop   (q_pop)
    );

    gmv_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_op    (q_op),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule

FILE: rtl/gmv_front.sv
// gmv_front: accepts input words, classifies them and queues them for the back end.
// Depends on gmv_pkg and gmv_in_if.
module gmv_front
    import gmv_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    gmv_in_if.sink          item,
    output logic            q_valid,
    output op_t             q_op,
    input  logic            q_pop
);

    op_t                 queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wptr_reg, wptr_next;
    logic [QPTR_W-1:0]   rptr_reg, rptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                push;
    logic                pop;
    op_t                 new_op;

    assign item.ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push       = item.valid && item.ready;
    assign pop        = q_pop && q_valid;
    assign q_valid    = (count_reg != '0);
    assign q_op       = queue_reg[rptr_reg];

    always_comb
    begin
        new_op.is_matrix = (item.func == FUNC_MATRIX);
        new_op.index     = item.vector_index;
        new_op.data      = item.data_word;
    end

    always_comb
    begin
        wptr_next  = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = pop  ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wptr_reg] <= new_op;
        end
    end

endmodule

FILE: rtl/gmv_back.sv
// gmv_back: vector store, row/word sequencing, AND-XOR accumulation and byte output.
// Depends on gmv_pkg and gmv_out_if.
module gmv_back
    import gmv_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  cfg_t            cfg,
    input  logic            q_valid,
    input  op_t             q_op,
    output logic            q_pop,
    gmv_out_if.source       result
);

    logic [WORD_W-1:0]     vec_mem [MAX_ROW_WORDS];
    logic [WORD_W-1:0]     vec_rd_reg;

    logic [ADDR_W-1:0]     word_pos_reg, word_pos_next;
    logic [ROW_POS_W-1:0]  row_pos_reg, row_pos_next;

    logic                  b2_valid_reg, b2_valid_next;
    logic [WORD_W-1:0]     b2_data_reg;
    logic                  b2_row_end_reg;
    logic                  b2_emit_reg;
    logic                  b2_final_reg;
    logic [BIT_POS_W-1:0]  b2_bit_reg;
    logic [BYTE_IDX_W-1:0] b2_byte_reg;

    logic [WORD_W-1:0]     acc_reg, acc_next;
    logic [MASK_W-1:0]     coll_reg, coll_next;

    logic                  out_valid_reg, out_valid_next;
    logic [BYTE_IDX_W-1:0] out_byte_reg;
    logic [MASK_W-1:0]     out_mask_reg;
    logic                  out_last_reg;

    logic                  adv;
    logic                  mat_pop;
    logic                  load_pop;
    logic                  row_end;
    logic                  final_row;
    logic                  emit;
    logic                  fire;
    logic [WORD_W-1:0]     acc_sum;
    logic [MASK_W-1:0]     coll_sum;

    assign adv      = !b2_valid_reg || !b2_emit_reg || !out_valid_reg || result.ready;
    assign q_pop    = adv;
    assign mat_pop  = q_valid && adv && q_op.is_matrix;
    assign load_pop = q_valid && adv && !q_op.is_matrix;
    assign fire     = b2_valid_reg && adv;

    assign row_end   = ({1'b0, word_pos_reg} + 1'b1) >= (ADDR_W + 1)'(cfg.eff_words);
    assign final_row = (ROW_COUNT_W'(row_pos_reg) + 1'b1) >= cfg.eff_rows;
    assign emit      = row_end && (final_row || (row_pos_reg[BIT_POS_W-1:0] == '1));

    always_comb
    begin
        word_pos_next = word_pos_reg;
        row_pos_next  = row_pos_reg;
        if (mat_pop)
        begin
            if (!row_end)
            begin
                word_pos_next = word_pos_reg + 1'b1;
            end
            else
            begin
                word_pos_next = '0;
                row_pos_next  = final_row ? '0 : row_pos_reg + 1'b1;
            end
        end
    end

    assign b2_valid_next = adv ? mat_pop : b2_valid_reg;

    always_comb
    begin
        acc_sum  = acc_reg ^ (b2_data_reg & vec_rd_reg);
        coll_sum = coll_reg | (MASK_W'(^acc_sum) << b2_bit_reg);
        acc_next = acc_reg;
        coll_next = coll_reg;
        if (fire)
        begin
            if (b2_row_end_reg)
            begin
                acc_next  = '0;
                coll_next = b2_emit_reg ? '0 : coll_sum;
            end
            else
            begin
                acc_next = acc_sum;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !result.ready;
        if (fire && b2_emit_reg)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_pos_reg  <= '0;
            row_pos_reg   <= '0;
            b2_valid_reg  <= 1'b0;
            b2_emit_reg   <= 1'b0;
            acc_reg       <= '0;
            coll_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            word_pos_reg  <= word_pos_next;
            row_pos_reg   <= row_pos_next;
            b2_valid_reg  <= b2_valid_next;
            acc_reg       <= acc_next;
            coll_reg      <= coll_next;
            out_valid_reg <= out_valid_next;
            if (mat_pop)
            begin
                b2_emit_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mat_pop)
        begin
            b2_data_reg    <= q_op.data;
            b2_row_end_reg <= row_end;
            b2_final_reg   <= final_row;
            b2_bit_reg     <= row_pos_reg[BIT_POS_W-1:0];
            b2_byte_reg    <= BYTE_IDX_W'(row_pos_reg >> BIT_POS_W);
        end
        if (fire && b2_emit_reg)
        begin
            out_byte_reg <= b2_byte_reg;
            out_mask_reg <= coll_sum;
            out_last_reg <= b2_final_reg;
        end
    end

    // vector store: write on load, registered read on matrix word
    always_ff @(posedge clk)
    begin
        if (load_pop)
        begin
            vec_mem[q_op.index] <= q_op.data;
        end
        if (mat_pop)
        begin
            vec_rd_reg <= vec_mem[word_pos_reg];
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.byte_index = out_byte_reg;
    assign result.xor_mask   = out_mask_reg;
    assign result.last_byte  = out_last_reg;

endmodule
